[design/dual_wiper_pot_angle_decoder_unit_defines.svh]
// Assertion helpers shared by the decoder sources.
// Both expect clk and rst_n in the enclosing scope.
`ifndef DUAL_WIPER_POT_ANGLE_DECODER_UNIT_DEFINES_SVH
`define DUAL_WIPER_POT_ANGLE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define DWPAD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DWPAD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/dwpad_pkg.sv]
`default_nettype none

package dwpad_pkg;

  localparam int ADC_BITS_DEF   = 12;
  localparam int ANGLE_BITS_DEF = 16;

  // degrees in one turn, used by the window test
  localparam int DEG_TURN       = 360;

  localparam logic [7:0] DEAD_BAND_RST = 8'd30;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND = 2'd2;

  typedef enum logic [1:0] {
    SUB_NONE     = 2'd0,
    SUB_B_FROM_A = 2'd1,
    SUB_A_FROM_B = 2'd2
  } sub_t;

  // sideband that travels down the pipeline beside the arithmetic
  typedef struct packed {
    logic vld;
    logic rng_err;
    sub_t sub;
  } pipe_tag_t;

endpackage

`default_nettype wire

[design/dual_wiper_pot_angle_decoder_unit.sv]
// Dual-wiper continuous potentiometer angle decoder. Each input transaction
// carries one pair of wiper ADC codes; each output transaction carries the
// shaft angle as a fraction of a turn (2^ANGLE_BITS = 360 degrees, rounded to
// nearest, ties up, wrapped modulo one turn), the substitution code and the
// range error flag. One transaction is taken every cycle while the skid buffer
// stays empty. Most of the pipeline is the chain of one-bit restoring stages
// that reduce the sum modulo 4R and then divide by 4R. A two-entry output
// register and skid buffer decouple the sides, so in_tready only drops once
// both hold a result. min_code, max_code and dead_band_degrees are to be
// written through the cfg port only while no transaction is in flight; the
// block itself does not enforce this. With max_code not above min_code every
// result reports range_error with a zero angle.
`default_nettype none

`include "dual_wiper_pot_angle_decoder_unit_defines.svh"

module dual_wiper_pot_angle_decoder_unit #(
  parameter int ADC_BITS   = dwpad_pkg::ADC_BITS_DEF,
  parameter int ANGLE_BITS = dwpad_pkg::ANGLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [ADC_BITS-1:0] wiper_a_code, [2*ADC_BITS-1:ADC_BITS] wiper_b_code, zero pad
  input  logic [((2*ADC_BITS+7)/8)*8-1:0]       in_tdata,
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [ANGLE_BITS-1:0] angle_turn, zero pad
  output logic [((ANGLE_BITS+7)/8)*8-1:0]       out_tdata,
  // [1:0] substitution, [2] range_error
  output logic [2:0]                            out_tuser,
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [dwpad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [(ADC_BITS > 8 ? ADC_BITS : 8)-1:0] cfg_wdata
);
  import dwpad_pkg::*;

  localparam int A     = ADC_BITS;
  localparam int OUT_W = ((ANGLE_BITS + 7) / 8) * 8;

  // ---- configuration registers ---------------------------------------------
  logic [A-1:0] min_code_r, max_code_r;
  logic [7:0]   dead_band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_code_r  <= '0;
      max_code_r  <= '1;
      dead_band_r <= DEAD_BAND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_CODE:  min_code_r  <= cfg_wdata[A-1:0];
        REG_MAX_CODE:  max_code_r  <= cfg_wdata[A-1:0];
        REG_DEAD_BAND: dead_band_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Span R and the turn divisor 4R; only meaningful when max > min, the
  // range error flag masks the result otherwise.
  logic [A-1:0] rng;
  logic [A+1:0] q_turn;

  assign rng    = max_code_r - min_code_r;
  assign q_turn = {rng, 2'b00};

  // ---- pipeline ------------------------------------------------------------
  logic out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;

  // Whole pipeline advances unless the skid stage is occupied.
  logic en;
  assign en        = !skid_vld_r;
  assign in_tready = en;

  pipe_tag_t    fr_tag;
  logic         fr_neg;
  logic [A+2:0] fr_mag;

  dwpad_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_tvalid),
    .a_code    (in_tdata[A-1:0]),
    .b_code    (in_tdata[2*A-1:A]),
    .min_code  (min_code_r),
    .max_code  (max_code_r),
    .rng       (rng),
    .dead_band (dead_band_r),
    .tag_o     (fr_tag),
    .s_neg_o   (fr_neg),
    .s_mag_o   (fr_mag)
  );

  pipe_tag_t             res_tag;
  logic [ANGLE_BITS-1:0] res_angle;

  dwpad_divider #(
    .ADC_BITS   (ADC_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .tag_i   (fr_tag),
    .s_neg_i (fr_neg),
    .s_mag_i (fr_mag),
    .q_i     (q_turn),
    .tag_o   (res_tag),
    .angle_o (res_angle)
  );

  // ---- output register and skid buffer -------------------------------------
  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle;
    logic                  err;
    sub_t                  sub;
  } res_t;

  res_t res_pay;
  assign res_pay = '{angle: res_angle, err: res_tag.rng_err, sub: res_tag.sub};

  res_t out_pay_r, out_pay_nxt, skid_pay_r, skid_pay_nxt;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_pay_nxt  = out_pay_r;
    skid_vld_nxt = skid_vld_r;
    skid_pay_nxt = skid_pay_r;
    if (skid_vld_r) begin
      // pipeline frozen; drain skid into the output register
      if (out_tready) begin
        out_pay_nxt  = skid_pay_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (res_tag.vld && (!out_vld_r || out_tready)) begin
      out_pay_nxt = res_pay;
      out_vld_nxt = 1'b1;
    end else if (res_tag.vld) begin
      skid_pay_nxt = res_pay;
      skid_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pay_r  <= out_pay_nxt;
    skid_pay_r <= skid_pay_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'(out_pay_r.angle);
  assign out_tuser  = {out_pay_r.err, out_pay_r.sub};

  // ---- assertions ----------------------------------------------------------
  `DWPAD_ASSERT_IMP(a_skid_behind_out, skid_vld_r, out_vld_r, "skid full with output empty")
  `DWPAD_ASSERT_NXT(a_skid_holds, skid_vld_r && !out_tready, skid_vld_r && $stable(skid_pay_r), "skid transaction lost")
  `DWPAD_ASSERT_NXT(a_frozen_result_kept, res_tag.vld && !en, res_tag.vld, "stalled pipeline dropped a transaction")
  `DWPAD_ASSERT_IMP(a_err_zero_angle, out_vld_r && out_pay_r.err, (out_pay_r.angle == '0) && (out_pay_r.sub == SUB_NONE), "range error with non-zero result")

endmodule

`default_nettype wire

[design/dwpad_front.sv]
`default_nettype none

// Window test, wiper rebuild and summed code; three register stages.
module dwpad_front #(
  parameter int ADC_BITS = dwpad_pkg::ADC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [ADC_BITS-1:0]      a_code,
  input  logic [ADC_BITS-1:0]      b_code,
  input  logic [ADC_BITS-1:0]      min_code,
  input  logic [ADC_BITS-1:0]      max_code,
  input  logic [ADC_BITS-1:0]      rng,
  input  logic [7:0]               dead_band,
  output dwpad_pkg::pipe_tag_t     tag_o,
  output logic                     s_neg_o,
  output logic [ADC_BITS+2:0]      s_mag_o
);
  import dwpad_pkg::*;

  localparam int A  = ADC_BITS;
  localparam int PW = A + 10;   // product width of the window compare
  localparam int SW = A + 4;    // signed width of the summed code

  // ---- stage 1: offsets from mid-scale -------------------------------------
  logic [A:0]          centre;
  logic signed [A+1:0] off_a, off_b;
  logic signed [A+1:0] neg_a, neg_b;
  logic                rng_err;

  assign centre  = {1'b0, min_code} + {1'b0, max_code};
  assign rng_err = (max_code <= min_code);
  assign off_a   = $signed({1'b0, a_code, 1'b0}) - $signed({1'b0, centre});
  assign off_b   = $signed({1'b0, b_code, 1'b0}) - $signed({1'b0, centre});
  assign neg_a   = -off_a;
  assign neg_b   = -off_b;

  logic          vld1_r, err1_r;
  logic [A-1:0]  a1_r, b1_r;
  logic [A:0]    abs_a1_r, abs_b1_r;
  logic          blw_a1_r, blw_b1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err1_r   <= rng_err;
      a1_r     <= a_code;
      b1_r     <= b_code;
      abs_a1_r <= off_a[A+1] ? neg_a[A:0] : off_a[A:0];
      abs_b1_r <= off_b[A+1] ? neg_b[A:0] : off_b[A:0];
      blw_a1_r <= off_a[A+1];
      blw_b1_r <= off_b[A+1];
    end
  end

  // ---- stage 2: strict window test, 360*|off| < d*R ------------------------
  logic [PW-1:0] prod_a, prod_b, lim;

  assign prod_a = PW'(abs_a1_r) * PW'(DEG_TURN);
  assign prod_b = PW'(abs_b1_r) * PW'(DEG_TURN);
  assign lim    = PW'(dead_band) * PW'(rng);

  logic          vld2_r, err2_r;
  logic [A-1:0]  a2_r, b2_r;
  logic          blw_a2_r, blw_b2_r, win_a2_r, win_b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err2_r   <= err1_r;
      a2_r     <= a1_r;
      b2_r     <= b1_r;
      blw_a2_r <= blw_a1_r;
      blw_b2_r <= blw_b1_r;
      win_a2_r <= (prod_a < lim);
      win_b2_r <= (prod_b < lim);
    end
  end

  // ---- stage 3: rebuild, then S = 2a + 2b -/+ R - 4*min --------------------
  logic signed [SW-1:0] wa, wb, rs, lo4, s_sum, s_inv;
  sub_t                 sub;

  always_comb begin
    wa  = $signed(SW'({a2_r, 1'b0}));
    wb  = $signed(SW'({b2_r, 1'b0}));
    rs  = $signed(SW'(rng));
    lo4 = $signed(SW'({min_code, 2'b00}));
    sub = SUB_NONE;
    if (err2_r) begin
      sub = SUB_NONE;
    end else if (win_a2_r) begin
      wb  = blw_a2_r ? wa + rs : wa - rs;
      sub = SUB_B_FROM_A;
    end else if (win_b2_r) begin
      wa  = blw_b2_r ? wb + rs : wb - rs;
      sub = SUB_A_FROM_B;
    end
    if (wb > wa) begin
      s_sum = wa + wb - rs - lo4;
    end else begin
      s_sum = wa + wb + rs - lo4;
    end
    s_inv = -s_sum;
  end

  pipe_tag_t      tag3_r;
  logic           neg3_r;
  logic [A+2:0]   mag3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag3_r <= '0;
    end else if (en) begin
      tag3_r <= '{vld: vld2_r, rng_err: err2_r, sub: sub};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg3_r <= s_sum[SW-1];
      mag3_r <= s_sum[SW-1] ? s_inv[A+2:0] : s_sum[A+2:0];
    end
  end

  assign tag_o   = tag3_r;
  assign s_neg_o = neg3_r;
  assign s_mag_o = mag3_r;

endmodule

`default_nettype wire

[design/dwpad_divider.sv]
`default_nettype none

// Pipelined reduction of S modulo 4R, then long division of the turn fraction.
// One restoring step per stage in both the modulo and the division chains.
module dwpad_divider #(
  parameter int ADC_BITS   = dwpad_pkg::ADC_BITS_DEF,
  parameter int ANGLE_BITS = dwpad_pkg::ANGLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  dwpad_pkg::pipe_tag_t   tag_i,
  input  logic                   s_neg_i,
  input  logic [ADC_BITS+2:0]    s_mag_i,
  input  logic [ADC_BITS+1:0]    q_i,
  output dwpad_pkg::pipe_tag_t   tag_o,
  output logic [ANGLE_BITS-1:0]  angle_o
);
  import dwpad_pkg::*;

  localparam int A  = ADC_BITS;
  localparam int MS = A + 2;          // modulo steps, shifts A+1 down to 0
  localparam int MW = 2 * A + 3;      // width of the shifted divisor
  localparam int DS = ANGLE_BITS + 1; // quotient bits, one spare for rounding

  // ---- modulo stages -------------------------------------------------------
  pipe_tag_t    mtag_r [MS];
  logic         mneg_r [MS];
  logic [A+2:0] mrem_r [MS];

  for (genvar i = 0; i < MS; i++) begin : g_mod
    localparam int K = MS - 1 - i;
    pipe_tag_t    tag_src;
    logic         neg_src;
    logic [A+2:0] rem_src;
    logic [MW-1:0] dvs;
    logic         take;

    if (i == 0) begin : g_first
      assign tag_src = tag_i;
      assign neg_src = s_neg_i;
      assign rem_src = s_mag_i;
    end else begin : g_next
      assign tag_src = mtag_r[i-1];
      assign neg_src = mneg_r[i-1];
      assign rem_src = mrem_r[i-1];
    end

    assign dvs  = MW'(q_i) << K;
    assign take = (MW'(rem_src) >= dvs);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mtag_r[i] <= '0;
      end else if (en) begin
        mtag_r[i] <= tag_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mneg_r[i] <= neg_src;
        mrem_r[i] <= take ? rem_src - dvs[A+2:0] : rem_src;
      end
    end
  end

  // ---- fold a negative sum back into [0, 4R) -------------------------------
  logic [A+1:0] mod_last;
  pipe_tag_t    ftag_r;
  logic [A+1:0] frac_r;

  assign mod_last = mrem_r[MS-1][A+1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ftag_r <= '0;
    end else if (en) begin
      ftag_r <= mtag_r[MS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frac_r <= (mneg_r[MS-1] && (mod_last != '0)) ? q_i - mod_last : mod_last;
    end
  end

  // ---- long division, frac * 2^(ANGLE_BITS+1) / 4R -------------------------
  pipe_tag_t     dtag_r [DS];
  logic [A+1:0]  drem_r [DS];
  logic [DS-1:0] dquo_r [DS];

  for (genvar j = 0; j < DS; j++) begin : g_div
    pipe_tag_t     tag_src;
    logic [A+1:0]  rem_src;
    logic [DS-1:0] quo_src;
    logic [A+2:0]  rem2, rem_sub;
    logic          ge;

    if (j == 0) begin : g_first
      assign tag_src = ftag_r;
      assign rem_src = frac_r;
      assign quo_src = '0;
    end else begin : g_next
      assign tag_src = dtag_r[j-1];
      assign rem_src = drem_r[j-1];
      assign quo_src = dquo_r[j-1];
    end

    assign rem2    = {rem_src, 1'b0};
    assign ge      = (rem2 >= {1'b0, q_i});
    assign rem_sub = rem2 - {1'b0, q_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dtag_r[j] <= '0;
      end else if (en) begin
        dtag_r[j] <= tag_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[j] <= ge ? rem_sub[A+1:0] : rem2[A+1:0];
        dquo_r[j] <= {quo_src[DS-2:0], ge};
      end
    end
  end

  // ---- round half up, wrap a full turn to zero -----------------------------
  logic [DS:0]           quo_inc;
  pipe_tag_t             otag_r;
  logic [ANGLE_BITS-1:0] angle_r;

  assign quo_inc = (DS + 1)'(dquo_r[DS-1]) + (DS + 1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      otag_r <= '0;
    end else if (en) begin
      otag_r <= dtag_r[DS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= dtag_r[DS-1].rng_err ? '0 : quo_inc[ANGLE_BITS:1];
    end
  end

  assign tag_o   = otag_r;
  assign angle_o = angle_r;

endmodule

`default_nettype wire
